@@ hw/rtl/fccw_pkg.sv @@
package fccw_pkg;

  // Sector size in bytes; one FAT32 entry is four bytes.
  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned EntriesPerSector = SECTOR_BYTES / 4;
  localparam int unsigned EntryShift = $clog2(EntriesPerSector);

  localparam int unsigned ClusterW = 28;
  localparam int unsigned SectorW  = 48;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [ClusterW-1:0] FirstSpecial = 28'h FFFFFF0;
  localparam logic [ClusterW-1:0] BadMark      = 28'h FFFFFF7;
  localparam logic [ClusterW-1:0] EocFirst     = 28'h FFFFFF8;
  localparam logic [ClusterW-1:0] MinCluster   = 28'd2;

  // Opcodes of an input word.
  localparam logic OpStart = 1'b0;
  localparam logic OpEntry = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPartStart = 3'd0;
  localparam logic [CfgIdxW-1:0] RegResSect   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFatCopies = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSectPerFat = 3'd3;
  localparam logic [CfgIdxW-1:0] RegClustShift = 3'd4;

  typedef enum logic [2:0] {
    StValid  = 3'd0,
    StEnd    = 3'd1,
    StBad    = 3'd2,
    StFree   = 3'd3,
    StClosed = 3'd4
  } status_e;

  function automatic logic is_valid_cluster(logic [ClusterW-1:0] v);
    return (v >= MinCluster) && (v < FirstSpecial);
  endfunction

endpackage

@@ hw/rtl/fat32_cluster_chain_walker_top.sv @@
// FAT32 cluster chain walker. A start word (opcode 0) opens a chain at
// start_cluster_i; each entry word (opcode 1) carries the raw FAT entry read
// for the current cluster, which is masked to 28 bits and classified as next
// cluster, end of chain, bad cluster or free/reserved. Every accepted word
// gives exactly one result word: status, current cluster, the cluster's first
// data sector and the FAT sector / entry index to fetch next (the last three
// are zero for any status other than valid). One word per cycle is taken
// unless out_stall_i holds a result; its result shows in the next cycle from
// the single result register of status and cluster, with sector sums from it
// and the configuration registers. The user must write configuration through
// the plain write port only while no word is in flight; it is not enforced.
module fat32_cluster_chain_walker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [fccw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fccw_pkg::CfgW-1:0]         cfg_wdata_i,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [fccw_pkg::ClusterW-1:0]     start_cluster_i,
  input  logic [31:0]                       entry_word_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [fccw_pkg::ClusterW-1:0]     cluster_out_o,
  output logic [fccw_pkg::SectorW-1:0]      data_sector_o,
  output logic [fccw_pkg::SectorW-1:0]      fat_sector_o,
  output logic [fccw_pkg::IndexW-1:0]       entry_index_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] part_start_q;
  logic [15:0] res_sect_q;
  logic [7:0]  fat_copies_q;
  logic [31:0] sect_per_fat_q;
  logic [2:0]  clust_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_start_q   <= '0;
      res_sect_q     <= 16'd32;
      fat_copies_q   <= 8'd2;
      sect_per_fat_q <= '0;
      clust_shift_q  <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fccw_pkg::RegPartStart:  part_start_q   <= cfg_wdata_i;
        fccw_pkg::RegResSect:    res_sect_q     <= cfg_wdata_i[15:0];
        fccw_pkg::RegFatCopies:  fat_copies_q   <= cfg_wdata_i[7:0];
        fccw_pkg::RegSectPerFat: sect_per_fat_q <= cfg_wdata_i;
        fccw_pkg::RegClustShift: clust_shift_q  <= cfg_wdata_i[2:0];
        default: ;  // indexes beyond the register list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register frees up when it is empty or being drained
  // ---------------------------------------------------------------------------
  logic res_valid_q;
  logic in_acc;

  assign in_stall_o = res_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------------
  // Chain state and classification of the incoming word
  // ---------------------------------------------------------------------------
  logic [fccw_pkg::ClusterW-1:0] cur_clust_q, cur_clust_d;
  logic                          chain_open_q, chain_open_d;
  fccw_pkg::status_e             status_d;
  logic [fccw_pkg::ClusterW-1:0] masked;

  assign masked = entry_word_i[fccw_pkg::ClusterW-1:0];

  always_comb begin
    cur_clust_d  = cur_clust_q;
    chain_open_d = chain_open_q;
    status_d     = fccw_pkg::StValid;
    if (opcode_i == fccw_pkg::OpStart) begin
      if (fccw_pkg::is_valid_cluster(start_cluster_i)) begin
        cur_clust_d  = start_cluster_i;
        chain_open_d = 1'b1;
      end else begin
        status_d = fccw_pkg::StFree;  // chain stays as it was
      end
    end else if (!chain_open_q) begin
      status_d = fccw_pkg::StClosed;
    end else if (fccw_pkg::is_valid_cluster(masked)) begin
      cur_clust_d = masked;
    end else begin
      // chain ends; the last good cluster is kept
      chain_open_d = 1'b0;
      if (masked >= fccw_pkg::EocFirst) begin
        status_d = fccw_pkg::StEnd;
      end else if (masked == fccw_pkg::BadMark) begin
        status_d = fccw_pkg::StBad;
      end else begin
        status_d = fccw_pkg::StFree;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_clust_q  <= '0;
      chain_open_q <= 1'b0;
    end else if (in_acc) begin
      cur_clust_q  <= cur_clust_d;
      chain_open_q <= chain_open_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  fccw_pkg::status_e             res_status_q;
  logic [fccw_pkg::ClusterW-1:0] res_clust_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_acc) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_status_q <= status_d;
      res_clust_q  <= cur_clust_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sector arithmetic on the registered cluster
  // ---------------------------------------------------------------------------
  logic [fccw_pkg::SectorW-1:0]  fat_base;
  logic [39:0]                   fat_area;
  logic [fccw_pkg::ClusterW-1:0] clust_rel;
  logic [fccw_pkg::SectorW-1:0]  clust_off;
  logic [fccw_pkg::SectorW-1:0]  data_sum;
  logic [fccw_pkg::SectorW-1:0]  fat_sum;
  logic [fccw_pkg::ClusterW-1:0] idx_full;
  logic                          is_ok;

  assign fat_base  = {16'd0, part_start_q} + {32'd0, res_sect_q};
  assign fat_area  = {32'd0, fat_copies_q} * {8'd0, sect_per_fat_q};
  assign clust_rel = res_clust_q - fccw_pkg::MinCluster;
  assign clust_off = {{(fccw_pkg::SectorW-fccw_pkg::ClusterW){1'b0}}, clust_rel}
                     << clust_shift_q;
  assign data_sum  = fat_base + {8'd0, fat_area} + clust_off;
  assign fat_sum   = fat_base
                   + {{(fccw_pkg::SectorW-fccw_pkg::ClusterW){1'b0}},
                      (res_clust_q >> fccw_pkg::EntryShift)};
  assign idx_full  = res_clust_q
                   & fccw_pkg::ClusterW'(fccw_pkg::EntriesPerSector - 1);
  assign is_ok     = (res_status_q == fccw_pkg::StValid);

  assign out_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign cluster_out_o = res_clust_q;
  assign data_sector_o = is_ok ? data_sum : '0;
  assign fat_sector_o  = is_ok ? fat_sum : '0;
  assign entry_index_o = is_ok ? idx_full[fccw_pkg::IndexW-1:0] : '0;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A valid result always names a usable cluster.
  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == fccw_pkg::StValid) |->
      (cluster_out_o >= fccw_pkg::MinCluster && cluster_out_o < fccw_pkg::FirstSpecial))
    else $error("valid status with unusable cluster");

  // The held result is the latest word, so a valid one means the chain is open
  // at that cluster.
  a_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == fccw_pkg::StValid) |->
      (chain_open_q && cur_clust_q == cluster_out_o))
    else $error("result and chain state disagree");

  // An entry word with no open chain reports closed and leaves state alone.
  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == fccw_pkg::OpEntry && !chain_open_q) |=>
      (status_o == fccw_pkg::StClosed && !chain_open_q && $stable(cur_clust_q)))
    else $error("entry word without open chain mishandled");

endmodule

@@ tb/fat32_chain_checker.sv @@
`timescale 1ns / 1ps

module fat32_chain_checker
  import fccw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,

  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                opcode_i,
  input  logic [ClusterW-1:0] start_cluster_i,
  input  logic [31:0]         entry_word_i,

  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [2:0]          status_i,
  input  logic [ClusterW-1:0] cluster_out_i,
  input  logic [SectorW-1:0]  data_sector_i,
  input  logic [SectorW-1:0]  fat_sector_i,
  input  logic [IndexW-1:0]   entry_index_i,

  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    status_e             status;
    logic [ClusterW-1:0] cluster;
    logic [SectorW-1:0]  data_sector;
    logic [SectorW-1:0]  fat_sector;
    logic [IndexW-1:0]   entry_index;
  } hop_t;

  // volume geometry as last written
  logic [31:0] part_start;
  logic [15:0] res_sectors;
  logic [7:0]  fat_count;
  logic [31:0] fat_len;
  logic [2:0]  clus_shift;

  // chain position
  logic [ClusterW-1:0] walk_cluster;
  logic                walk_open;

  hop_t        expected_hops[$];
  int unsigned mismatches;
  int unsigned waiting;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  function automatic logic is_link(logic [ClusterW-1:0] v);
    return (v >= MinCluster) && (v < FirstSpecial);
  endfunction

  // result for the current position; sector fields only on a valid hop
  function automatic hop_t locate(status_e st);
    hop_t        h;
    logic [63:0] base;
    logic [63:0] c;
    c    = 64'(walk_cluster);
    base = 64'(part_start) + 64'(res_sectors);
    h.status      = st;
    h.cluster     = walk_cluster;
    h.data_sector = '0;
    h.fat_sector  = '0;
    h.entry_index = '0;
    if (st == StValid) begin
      h.data_sector = SectorW'(base + 64'(fat_count) * 64'(fat_len) + ((c - 64'd2) << clus_shift));
      h.fat_sector  = SectorW'(base + c / EntriesPerSector);
      h.entry_index = IndexW'(c % EntriesPerSector);
    end
    return h;
  endfunction

  function automatic hop_t next_hop(logic op, logic [ClusterW-1:0] sc, logic [31:0] ew);
    logic [ClusterW-1:0] v;
    v = ew[ClusterW-1:0];
    if (op == OpStart) begin
      if (!is_link(sc)) return locate(StFree);
      walk_cluster = sc;
      walk_open    = 1'b1;
      return locate(StValid);
    end
    if (!walk_open) return locate(StClosed);
    if (is_link(v)) begin
      walk_cluster = v;
      return locate(StValid);
    end
    walk_open = 1'b0;
    if (v >= EocFirst) return locate(StEnd);
    if (v == BadMark) return locate(StBad);
    return locate(StFree);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hop_t want;
    if (!rst_ni) begin
      part_start   = '0;
      res_sectors  = 16'd32;
      fat_count    = 8'd2;
      fat_len      = '0;
      clus_shift   = 3'd3;
      walk_cluster = '0;
      walk_open    = 1'b0;
      expected_hops.delete();
    end else begin
      // retire first: a word taken at this edge cannot have its result yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_hops.size() == 0) begin
          $error("result word with nothing expected: status %0d cluster 0x%0h",
                 status_i, cluster_out_i);
          mismatches++;
        end else begin
          want = expected_hops.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("cluster_out", 64'(want.cluster), 64'(cluster_out_i));
          check_field("data_sector", 64'(want.data_sector), 64'(data_sector_i));
          check_field("fat_sector", 64'(want.fat_sector), 64'(fat_sector_i));
          check_field("entry_index", 64'(want.entry_index), 64'(entry_index_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegPartStart:  part_start  = cfg_wdata_i;
          RegResSect:    res_sectors = cfg_wdata_i[15:0];
          RegFatCopies:  fat_count   = cfg_wdata_i[7:0];
          RegSectPerFat: fat_len     = cfg_wdata_i;
          RegClustShift: clus_shift  = cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_hops.push_back(next_hop(opcode_i, start_cluster_i, entry_word_i));
    end
    waiting = expected_hops.size();
  end

endmodule

@@ tb/fat32_cluster_chain_walker_top_test.sv @@
`timescale 1ns / 1ps

module fat32_cluster_chain_walker_top_test;
  import fccw_pkg::*;

  // all inputs known from time zero
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgW-1:0]     cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic                opcode_i        = OpStart;
  logic [ClusterW-1:0] start_cluster_i = '0;
  logic [31:0]         entry_word_i    = '0;
  logic                out_stall_i     = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [2:0]          status_o;
  logic [ClusterW-1:0] cluster_out_o;
  logic [SectorW-1:0]  data_sector_o;
  logic [SectorW-1:0]  fat_sector_o;
  logic [IndexW-1:0]   entry_index_o;

  int unsigned fails;
  int unsigned pending;
  int unsigned words_sent = 0;
  // set for the closing stretch: no gaps from the sender, no stalls from the sink
  logic        calm = 1'b0;

  always #2 clk_i = ~clk_i;

  fat32_cluster_chain_walker_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .start_cluster_i (start_cluster_i),
    .entry_word_i    (entry_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .cluster_out_o   (cluster_out_o),
    .data_sector_o   (data_sector_o),
    .fat_sector_o    (fat_sector_o),
    .entry_index_o   (entry_index_o)
  );

  // Checker sits beside the block on the same wires: it keeps its own chain
  // state and volume geometry and compares every result word it sees.
  fat32_chain_checker chain_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .opcode_i        (opcode_i),
    .start_cluster_i (start_cluster_i),
    .entry_word_i    (entry_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .cluster_out_i   (cluster_out_o),
    .data_sector_i   (data_sector_o),
    .fat_sector_i    (fat_sector_o),
    .entry_index_i   (entry_index_o),
    .errors_o        (fails),
    .pending_o       (pending)
  );

  // Sink back-pressure: random stall bursts, at most one assignment per
  // falling edge, so a burst that carries on is never dropped and re-raised.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && rst_ni && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: far beyond the slowest clean run (about a thousand words, each
  // behind the longest sender gap and a chain of stall bursts).
  initial begin
    #2000000;
    $display("fat32_cluster_chain_walker_top_test: done, errors");
    $finish;
  end

  // Present one word at a falling edge and hold it until taken. Ends on the
  // falling edge after acceptance with valid still high, so back-to-back
  // words keep valid up without a glitch.
  task automatic push_word(logic op, logic [ClusterW-1:0] sc, logic [31:0] ew);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    start_cluster_i <= sc;
    entry_word_i    <= ew;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every result, then let the result register
  // empty, before touching the volume registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_volume(logic [31:0] part, logic [15:0] res, logic [7:0] copies,
                            logic [31:0] spf, logic [2:0] shift);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegPartStart;
    cfg_wdata_i <= part;
    @(negedge clk_i);
    cfg_index_i <= RegResSect;
    cfg_wdata_i <= CfgW'(res);
    @(negedge clk_i);
    cfg_index_i <= RegFatCopies;
    cfg_wdata_i <= CfgW'(copies);
    @(negedge clk_i);
    cfg_index_i <= RegSectPerFat;
    cfg_wdata_i <= spf;
    @(negedge clk_i);
    cfg_index_i <= RegClustShift;
    cfg_wdata_i <= CfgW'(shift);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Next-cluster values: mostly anywhere, some from small volumes, some on the edges
  // of the valid range and of a FAT sector.
  function automatic logic [ClusterW-1:0] pick_cluster();
    case ($urandom_range(0, 5))
      0, 1: return ClusterW'($urandom_range(2, 4000));
      2: begin
        case ($urandom_range(0, 3))
          0: return MinCluster;
          1: return ClusterW'(FirstSpecial - 1);
          2: return ClusterW'(EntriesPerSector - 1);
          default: return ClusterW'(EntriesPerSector);
        endcase
      end
      default: return ClusterW'($urandom_range(2, 32'h0FFFFFEF));
    endcase
  endfunction

  // Word that closes a chain: end-of-chain, bad mark, or free/reserved.
  function automatic logic [ClusterW-1:0] pick_terminator();
    case ($urandom_range(0, 3))
      0, 1: return ClusterW'($urandom_range(32'h0FFFFFF8, 32'h0FFFFFFF));
      2: return BadMark;
      default: begin
        if ($urandom_range(0, 1) == 0) return ClusterW'($urandom_range(0, 1));
        return ClusterW'($urandom_range(32'h0FFFFFF0, 32'h0FFFFFF6));
      end
    endcase
  endfunction

  // The top nibble of a FAT32 entry is ignored; keep it random.
  function automatic logic [31:0] fat_word(logic [ClusterW-1:0] c);
    return {4'($urandom), c};
  endfunction

  // One well-formed chain walk with random content, sometimes left open,
  // restarted invalidly midway, or poked again after it has closed.
  task automatic walk_chain();
    int unsigned hops;
    hops = $urandom_range(0, 8);
    push_word(OpStart, pick_cluster(), $urandom);
    repeat (hops) push_word(OpEntry, ClusterW'($urandom), fat_word(pick_cluster()));
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        push_word(OpStart, pick_terminator(), $urandom);
        push_word(OpEntry, ClusterW'($urandom), fat_word(pick_cluster()));
      end
      default: begin
        push_word(OpEntry, ClusterW'($urandom), fat_word(pick_terminator()));
        if ($urandom_range(0, 3) == 0)
          push_word(OpEntry, ClusterW'($urandom), $urandom);
      end
    endcase
  endtask

  task automatic run_random(int unsigned n);
    int unsigned target;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(0, 4) == 0)
        push_word(1'($urandom), ClusterW'($urandom), $urandom);
      else
        walk_chain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words on the reset geometry.
    // entry with nothing open
    push_word(OpEntry, '0, 32'h0000_0005);
    // starts on free/reserved and special values never open a chain
    push_word(OpStart, 28'd0, '0);
    push_word(OpStart, 28'd1, '0);
    push_word(OpStart, FirstSpecial, '0);
    push_word(OpStart, 28'hFFFFFFF, 32'hFFFF_FFFF);
    // lowest cluster, hop to the highest, then end of chain
    push_word(OpStart, MinCluster, '0);
    push_word(OpEntry, '0, 32'hFFFF_FFEF);
    push_word(OpEntry, 28'hFFFFFFF, 32'h0FFF_FFF8);
    // chain now closed
    push_word(OpEntry, '0, 32'h0000_0010);
    // top nibble masked off, then bad mark
    push_word(OpStart, ClusterW'(FirstSpecial - 1), '0);
    push_word(OpEntry, '0, 32'hF000_0003);
    push_word(OpEntry, '0, 32'h0FFF_FFF7);
    // across a FAT sector boundary, last end-of-chain code
    push_word(OpStart, ClusterW'(EntriesPerSector - 1), '0);
    push_word(OpEntry, '0, 32'(EntriesPerSector));
    push_word(OpEntry, '0, 32'h0FFF_FFFF);
    // free and reserved entries close the chain
    push_word(OpStart, 28'd5, '0);
    push_word(OpEntry, '0, 32'h0000_0000);
    push_word(OpStart, 28'd5, '0);
    push_word(OpEntry, '0, 32'h0000_0001);
    push_word(OpStart, 28'd9, '0);
    push_word(OpEntry, '0, 32'h0FFF_FFF6);
    push_word(OpStart, 28'd9, '0);
    push_word(OpEntry, '0, 32'h0FFF_FFF0);
    // invalid restart leaves an open chain where it was
    push_word(OpStart, 28'd6, '0);
    push_word(OpStart, 28'd0, '0);
    push_word(OpEntry, '0, 32'h0000_0007);
    settle();

    // typical small volume
    set_volume(32'd2048, 16'd32, 8'd2, 32'd15000, 3'd3);
    run_random(180);
    settle();

    // every register at its top
    set_volume(32'hFFFF_FFFF, 16'hFFFF, 8'd255, 32'hFFFF_FFFF, 3'd7);
    run_random(180);
    settle();

    // every register at its floor, the FAT count at one
    set_volume(32'd0, 16'd0, 8'd1, 32'd0, 3'd0);
    run_random(180);
    settle();

    // random geometry; the closing stretch runs without gaps or stalls
    set_volume($urandom, 16'($urandom), 8'($urandom_range(1, 255)), $urandom,
               3'($urandom));
    run_random(180);
    calm = 1'b1;
    run_random(180);
    settle();

    if (fails == 0 && pending == 0) begin
      $display("fat32_cluster_chain_walker_top_test: done, clean");
    end else begin
      $display("fat32_cluster_chain_walker_top_test: done, errors");
    end
    $finish;
  end

endmodule
